// File: rtl/core/fsc_pkg.sv
// ---------------------------------------------------------------------------
// fsc_pkg
// shared types, constants and sequence tables of the flash command sequencer
// ---------------------------------------------------------------------------
package fsc_pkg;

  localparam int BankBitsDef   = 5;
  localparam int OffsetBitsDef = 14;
  localparam int CmdqDepthDef  = 2;
  localparam int BankMaxW      = 8;
  localparam int FlashAddrW    = 19;
  localparam int BusAddrW      = 16;
  localparam int BusDataW      = 8;
  localparam int StepW         = 3;

  typedef enum logic [1:0] {
    ACT_READ    = 2'd0,
    ACT_PROGRAM = 2'd1,
    ACT_ERASE   = 2'd2,
    ACT_READ_ID = 2'd3
  } action_t;

  localparam logic [BusAddrW-1:0] MapperAddr = 16'hFFFF;
  localparam logic [BusAddrW-1:0] UnlockA    = 16'h5555;
  localparam logic [BusAddrW-1:0] UnlockB    = 16'h2AAA;
  localparam logic [BusAddrW-1:0] WindowBase = 16'h8000;
  localparam logic [BusAddrW-1:0] IdExitAddr = 16'h0000;

  localparam logic [BusDataW-1:0] CmdUnlock1   = 8'hAA;
  localparam logic [BusDataW-1:0] CmdUnlock2   = 8'h55;
  localparam logic [BusDataW-1:0] CmdProgram   = 8'hA0;
  localparam logic [BusDataW-1:0] CmdEraseSet  = 8'h80;
  localparam logic [BusDataW-1:0] CmdChipErase = 8'h10;
  localparam logic [BusDataW-1:0] CmdIdEntry   = 8'h90;
  localparam logic [BusDataW-1:0] CmdIdExit    = 8'hF0;

  // classified command handed from front to back
  typedef struct packed {
    action_t               action;
    logic                  bank_wr;
    logic [BankMaxW-1:0]   bank;
    logic [BusAddrW-1:0]   window;
    logic [BusDataW-1:0]   wdata;
  } cmd_t;

  typedef struct packed {
    logic [BusAddrW-1:0] addr;
    logic [BusDataW-1:0] data;
    logic                is_read;
    logic                last;
  } bus_cycle_t;

  // number of table cycles, bank write not counted
  function automatic logic [StepW-1:0] seq_len(input action_t act);
    logic [StepW-1:0] len;
    unique case (act)
      ACT_READ:    len = 3'd1;
      ACT_PROGRAM: len = 3'd4;
      ACT_ERASE:   len = 3'd6;
      ACT_READ_ID: len = 3'd6;
      default:     len = 3'd1;
    endcase
    return len;
  endfunction

  // step before which a pending mapper write goes out
  function automatic logic bank_slot(input action_t act, input logic [StepW-1:0] step);
    logic hit;
    unique case (act)
      ACT_READ:    hit = (step == 3'd0);
      ACT_PROGRAM: hit = (step == 3'd0);
      ACT_READ_ID: hit = (step == 3'd3);
      default:     hit = 1'b0;
    endcase
    return hit;
  endfunction

  // bus cycle of one table step, last flag left clear
  function automatic bus_cycle_t seq_cycle(input cmd_t cmd, input logic [StepW-1:0] step);
    bus_cycle_t c;
    c = '0;
    unique case (cmd.action)
      ACT_READ: begin
        c.addr    = cmd.window;
        c.is_read = 1'b1;
      end
      ACT_PROGRAM: begin
        unique case (step)
          3'd0:    begin c.addr = UnlockA;    c.data = CmdUnlock1; end
          3'd1:    begin c.addr = UnlockB;    c.data = CmdUnlock2; end
          3'd2:    begin c.addr = UnlockA;    c.data = CmdProgram; end
          default: begin c.addr = cmd.window; c.data = cmd.wdata;  end
        endcase
      end
      ACT_ERASE: begin
        unique case (step)
          3'd0:    begin c.addr = UnlockA; c.data = CmdUnlock1;  end
          3'd1:    begin c.addr = UnlockB; c.data = CmdUnlock2;  end
          3'd2:    begin c.addr = UnlockA; c.data = CmdEraseSet; end
          3'd3:    begin c.addr = UnlockA; c.data = CmdUnlock1;  end
          3'd4:    begin c.addr = UnlockB; c.data = CmdUnlock2;  end
          default: begin c.addr = UnlockA; c.data = CmdChipErase; end
        endcase
      end
      default: begin
        unique case (step)
          3'd0:    begin c.addr = UnlockA; c.data = CmdUnlock1; end
          3'd1:    begin c.addr = UnlockB; c.data = CmdUnlock2; end
          3'd2:    begin c.addr = UnlockA; c.data = CmdIdEntry; end
          3'd3:    begin c.addr = WindowBase;         c.is_read = 1'b1; end
          3'd4:    begin c.addr = WindowBase | 16'h1; c.is_read = 1'b1; end
          default: begin c.addr = IdExitAddr; c.data = CmdIdExit; end
        endcase
      end
    endcase
    return c;
  endfunction

endpackage

// File: rtl/core/banked_flash_command_sequencer_top.sv
// ---------------------------------------------------------------------------
// banked_flash_command_sequencer_top
// paged parallel flash command sequencer: commands in, bus cycles out
// ---------------------------------------------------------------------------
// path: a command passes the queue and the sequencer command register before its
//   first bus cycle is registered in the result stage
// throughput: one bus cycle per clock unless a held result stalls it; a command
//   is its cycle table plus any mapper write (longest: read id with a bank change)
// reset: synchronous; clears queues and marks the bank cache as empty, so the
//   first banked access always writes the mapper
module banked_flash_command_sequencer_top #(
  parameter int BANK_BITS   = fsc_pkg::BankBitsDef,
  parameter int OFFSET_BITS = fsc_pkg::OffsetBitsDef,
  parameter int CMDQ_DEPTH  = fsc_pkg::CmdqDepthDef
) (
  input  logic                           clk,
  input  logic                           rst,
  // command side
  input  logic                           push,
  output logic                           full,
  input  logic [1:0]                     action,
  input  logic [fsc_pkg::FlashAddrW-1:0] flash_address,
  input  logic [fsc_pkg::BusDataW-1:0]   write_data,
  // bus cycle side
  output logic                           empty,
  input  logic                           pop,
  output logic [fsc_pkg::BusAddrW-1:0]   bus_address,
  output logic [fsc_pkg::BusDataW-1:0]   bus_data,
  output logic                           bus_is_read,
  output logic                           last
);
  import fsc_pkg::*;

  // front to queue
  logic       q_push;
  logic       q_full;
  cmd_t       q_in_cmd;
  // queue to back
  logic       q_valid;
  logic       q_pop;
  cmd_t       q_out_cmd;
  // result stage
  logic       out_valid;
  bus_cycle_t out_cycle;

  // intake: splits the address and decides whether a mapper write is needed;
  // the bank cache is updated here in command order
  fsc_front #(
    .BANK_BITS   (BANK_BITS),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .action        (action),
    .flash_address (flash_address),
    .write_data    (write_data),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_cmd         (q_in_cmd)
  );

  // decoupling queue, lets intake run ahead of the sequencer
  fsc_cmdq #(
    .DEPTH (CMDQ_DEPTH)
  ) u_cmdq (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (q_push),
    .wr_cmd   (q_in_cmd),
    .q_full   (q_full),
    .rd_en    (q_pop),
    .rd_valid (q_valid),
    .rd_cmd   (q_out_cmd)
  );

  // sequencer: one bus cycle per clock into the result register while it is free
  // or popped; next command loaded in the same clock as the current one's final cycle
  fsc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_cmd     (q_out_cmd),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_cycle (out_cycle),
    .pop       (pop)
  );

  assign empty       = !out_valid;
  assign bus_address = out_cycle.addr;
  assign bus_data    = out_cycle.data;
  assign bus_is_read = out_cycle.is_read;
  assign last        = out_cycle.last;

  // nothing to transfer right after reset
  a_empty_after_reset: assert property (@(posedge clk) rst |=> empty)
    else $error("result pending after reset");

  // a mapper write is always followed by the access it prepares
  a_bank_write_not_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && !bus_is_read && bus_address == MapperAddr) |-> !last)
    else $error("mapper write marked as last cycle");

  // read cycles drive no data
  a_read_data_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && bus_is_read) |-> (bus_data == '0))
    else $error("read cycle with nonzero data");

  // a full front means commands are waiting for the sequencer
  a_full_has_cmd: assert property (@(posedge clk) disable iff (rst)
    full |-> q_valid)
    else $error("full with empty command queue");

endmodule

// File: rtl/core/fsc_front.sv
// ---------------------------------------------------------------------------
// fsc_front
// command intake: address split, bank cache lookup and update
// ---------------------------------------------------------------------------
module fsc_front #(
  parameter int BANK_BITS   = fsc_pkg::BankBitsDef,
  parameter int OFFSET_BITS = fsc_pkg::OffsetBitsDef
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic [1:0]                    action,
  input  logic [fsc_pkg::FlashAddrW-1:0] flash_address,
  input  logic [fsc_pkg::BusDataW-1:0]  write_data,
  input  logic                          q_full,
  output logic                          q_push,
  output fsc_pkg::cmd_t                 q_cmd
);
  import fsc_pkg::*;

  logic [BANK_BITS-1:0]  cached_bank;
  logic                  cached_valid;
  logic [FlashAddrW-1:0] addr_shift;
  logic [BANK_BITS-1:0]  bank_sel;
  logic                  banked;
  logic                  bank_wr;
  action_t               act;

  assign act        = action_t'(action);
  assign addr_shift = flash_address >> OFFSET_BITS;
  // read id always selects bank 0
  assign bank_sel   = (act == ACT_READ_ID) ? '0 : addr_shift[BANK_BITS-1:0];
  assign banked     = (act != ACT_ERASE);
  assign bank_wr    = banked && (!cached_valid || (cached_bank != bank_sel));

  assign full   = q_full;
  assign q_push = push && !q_full;

  always_comb begin
    q_cmd         = '0;
    q_cmd.action  = act;
    q_cmd.bank_wr = bank_wr;
    q_cmd.bank    = BankMaxW'(bank_sel);
    q_cmd.window  = BusAddrW'(flash_address[OFFSET_BITS-1:0]) | WindowBase;
    q_cmd.wdata   = write_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cached_valid <= 1'b0;
      cached_bank  <= '1;
    end else if (q_push && bank_wr) begin
      cached_valid <= 1'b1;
      cached_bank  <= bank_sel;
    end
  end

endmodule

// File: rtl/core/fsc_cmdq.sv
// ---------------------------------------------------------------------------
// fsc_cmdq
// short command queue between intake and sequencer
// ---------------------------------------------------------------------------
module fsc_cmdq #(
  parameter int DEPTH = fsc_pkg::CmdqDepthDef
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  fsc_pkg::cmd_t wr_cmd,
  output logic          q_full,
  input  logic          rd_en,
  output logic          rd_valid,
  output fsc_pkg::cmd_t rd_cmd
);
  import fsc_pkg::*;

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  cmd_t            slots [DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            do_wr;
  logic            do_rd;

  assign q_full   = (count == CntW'(DEPTH));
  assign rd_valid = (count != '0);
  assign rd_cmd   = slots[rd_ptr];
  assign do_wr    = wr_en && !q_full;
  assign do_rd    = rd_en && rd_valid;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: rtl/core/fsc_back.sv
// ---------------------------------------------------------------------------
// fsc_back
// bus cycle sequencer with registered result stage
// ---------------------------------------------------------------------------
module fsc_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  input  fsc_pkg::cmd_t        q_cmd,
  output logic                 q_pop,
  output logic                 out_valid,
  output fsc_pkg::bus_cycle_t  out_cycle,
  input  logic                 pop
);
  import fsc_pkg::*;

  logic             busy;
  cmd_t             cur;
  logic [StepW-1:0] step;
  logic             bank_pend;
  logic             pop_ok;
  logic             adv;
  logic             insert_bank;
  logic             done;
  bus_cycle_t       cyc;

  assign pop_ok      = pop && out_valid;
  assign adv         = busy && (!out_valid || pop_ok);
  assign insert_bank = bank_pend && bank_slot(cur.action, step);
  assign done        = adv && cyc.last;
  assign q_pop       = q_valid && (!busy || done);

  always_comb begin
    if (insert_bank) begin
      cyc         = '0;
      cyc.addr    = MapperAddr;
      cyc.data    = cur.bank;
    end else begin
      cyc         = seq_cycle(cur, step);
      cyc.last    = (step == seq_len(cur.action) - 3'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_cmd;
    end
    if (adv) begin
      out_cycle <= cyc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      step      <= '0;
      bank_pend <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (q_pop) begin
        busy      <= 1'b1;
        step      <= '0;
        bank_pend <= q_cmd.bank_wr;
      end else if (adv) begin
        if (insert_bank) begin
          bank_pend <= 1'b0;
        end else begin
          step <= step + 1'b1;
        end
        if (done) begin
          busy <= 1'b0;
        end
      end
      if (adv) begin
        out_valid <= 1'b1;
      end else if (pop_ok) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
